// ===== rtl/core/aftf_pkg.sv =====
package aftf_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int STEP_W = 5;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [STEP_W-1:0] step_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TYPE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ID = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOP_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_OPTIONS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LENGTH = 3'd5;

    // Reset values of the registers.
    localparam logic [ADDR_W-1:0] RST_DEST_ADDRESS = 64'd0;
    localparam byte_t RST_FRAME_TYPE = 8'd16;
    localparam byte_t RST_FRAME_ID = 8'd0;
    localparam byte_t RST_HOP_LIMIT = 8'd0;
    localparam byte_t RST_TX_OPTIONS = 8'd0;
    localparam byte_t RST_PAYLOAD_LENGTH = 8'd64;

    // Frame constants.
    localparam byte_t START_DELIM = 8'h7E;
    localparam byte_t LEN_MSB = 8'h00;
    localparam byte_t LEN_BASE = 8'd14;
    localparam byte_t MAX_PAYLOAD = 8'd241;
    localparam byte_t CONST_FF = 8'hFF;
    localparam byte_t CONST_FE = 8'hFE;

    // Sequencer steps: one output word per step.
    localparam step_t STEP_SOF = 5'd0;
    localparam step_t STEP_LEN_MSB = 5'd1;
    localparam step_t STEP_LEN_LSB = 5'd2;
    localparam step_t STEP_TYPE = 5'd3;
    localparam step_t STEP_ID = 5'd4;
    localparam step_t STEP_DEST_FIRST = 5'd5;
    localparam step_t STEP_DEST_LAST = 5'd12;
    localparam step_t STEP_FF = 5'd13;
    localparam step_t STEP_FE = 5'd14;
    localparam step_t STEP_RADIUS = 5'd15;
    localparam step_t STEP_OPTION = 5'd16;
    localparam step_t STEP_PAYLOAD = 5'd17;
    localparam step_t STEP_CSUM = 5'd18;

    typedef struct packed {
        logic [ADDR_W-1:0] dest_address;
        byte_t frame_type;
        byte_t frame_id;
        byte_t hop_limit;
        byte_t tx_options;
        byte_t eff_length;
    } cfg_t;

    function automatic byte_t clamp_length(input byte_t len);
        byte_t n;
        n = len;
        if (n == 8'd0)
        begin
            n = 8'd1;
        end
        else if (n > MAX_PAYLOAD)
        begin
            n = MAX_PAYLOAD;
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/aftf_cfg_regs.sv =====
module aftf_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aftf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [aftf_pkg::ADDR_W-1:0]        cfg_data,
    output aftf_pkg::cfg_t                     cfg
);

    logic [aftf_pkg::ADDR_W-1:0] dest_address_reg;
    aftf_pkg::byte_t frame_type_reg;
    aftf_pkg::byte_t frame_id_reg;
    aftf_pkg::byte_t hop_limit_reg;
    aftf_pkg::byte_t tx_options_reg;
    aftf_pkg::byte_t payload_length_reg;
    aftf_pkg::byte_t wr_byte;

    assign cfg_ready = 1'b1;
    assign wr_byte = cfg_data[aftf_pkg::BYTE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_address_reg <= aftf_pkg::RST_DEST_ADDRESS;
            frame_type_reg <= aftf_pkg::RST_FRAME_TYPE;
            frame_id_reg <= aftf_pkg::RST_FRAME_ID;
            hop_limit_reg <= aftf_pkg::RST_HOP_LIMIT;
            tx_options_reg <= aftf_pkg::RST_TX_OPTIONS;
            payload_length_reg <= aftf_pkg::RST_PAYLOAD_LENGTH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aftf_pkg::REG_DEST_ADDRESS: dest_address_reg <= cfg_data;
                aftf_pkg::REG_FRAME_TYPE: frame_type_reg <= wr_byte;
                aftf_pkg::REG_FRAME_ID: frame_id_reg <= wr_byte;
                aftf_pkg::REG_HOP_LIMIT: hop_limit_reg <= wr_byte;
                aftf_pkg::REG_TX_OPTIONS: tx_options_reg <= wr_byte;
                aftf_pkg::REG_PAYLOAD_LENGTH: payload_length_reg <= wr_byte;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.dest_address = dest_address_reg;
        cfg.frame_type = frame_type_reg;
        cfg.frame_id = frame_id_reg;
        cfg.hop_limit = hop_limit_reg;
        cfg.tx_options = tx_options_reg;
        cfg.eff_length = aftf_pkg::clamp_length(payload_length_reg);
    end

endmodule

// ===== rtl/core/api_frame_transmit_framer_unit.sv =====
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tdata: payload_byte
// m_axis    out        tdata: tx_byte; tlast: run_last; tuser: frame_end
// cfg       in         cfg_index, cfg_data (register write)
//
// One output word leaves per cycle while m_tready is high; the header/payload/checksum
// sequencer is the limit. A frame's first word gives 17 header words and its payload,
// a middle word its payload, the last payload and checksum, a one-word frame all three.
// A new word is taken in the cycle the held word emits its last output.
// The output register holds while m_tready is low; the input stalls behind it.
// Reset starts a new frame with the register reset values.
module api_frame_transmit_framer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] payload_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] tx_byte
    output logic                               m_tlast,
    output logic                               m_tuser,   // [0] frame_end
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aftf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [aftf_pkg::ADDR_W-1:0]        cfg_data
);

    aftf_pkg::cfg_t cfg;

    logic in_valid_reg, in_valid_next;
    aftf_pkg::byte_t in_byte_reg;
    aftf_pkg::step_t step_reg, step_next;
    aftf_pkg::byte_t pos_reg, pos_next;
    aftf_pkg::byte_t sum_reg, sum_next;
    logic out_valid_reg, out_valid_next;
    aftf_pkg::byte_t out_byte_reg;
    logic out_last_reg, out_end_reg;

    logic out_adv;
    logic emit;
    logic frame_done;
    logic item_done;
    logic load;
    logic [2:0] dest_sel;
    aftf_pkg::byte_t cur_byte;
    logic cur_end;
    logic [aftf_pkg::BYTE_W:0] pos_inc;

    aftf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_adv = !out_valid_reg || m_tready;
    assign emit = in_valid_reg && out_adv;
    assign pos_inc = {1'b0, pos_reg} + 9'd1;
    assign frame_done = pos_inc >= {1'b0, cfg.eff_length};
    assign dest_sel = 3'(aftf_pkg::STEP_DEST_LAST - step_reg);
    assign item_done = (step_reg == aftf_pkg::STEP_CSUM)
                    || (step_reg == aftf_pkg::STEP_PAYLOAD && !frame_done);
    assign s_tready = !in_valid_reg || (emit && item_done);
    assign load = s_tvalid && s_tready;

    always_comb
    begin
        cur_end = 1'b0;
        case (step_reg) inside
            aftf_pkg::STEP_SOF: cur_byte = aftf_pkg::START_DELIM;
            aftf_pkg::STEP_LEN_MSB: cur_byte = aftf_pkg::LEN_MSB;
            aftf_pkg::STEP_LEN_LSB: cur_byte = aftf_pkg::LEN_BASE + cfg.eff_length;
            aftf_pkg::STEP_TYPE: cur_byte = cfg.frame_type;
            aftf_pkg::STEP_ID: cur_byte = cfg.frame_id;
            [aftf_pkg::STEP_DEST_FIRST:aftf_pkg::STEP_DEST_LAST]:
                cur_byte = cfg.dest_address[{dest_sel, 3'b000} +: aftf_pkg::BYTE_W];
            aftf_pkg::STEP_FF: cur_byte = aftf_pkg::CONST_FF;
            aftf_pkg::STEP_FE: cur_byte = aftf_pkg::CONST_FE;
            aftf_pkg::STEP_RADIUS: cur_byte = cfg.hop_limit;
            aftf_pkg::STEP_OPTION: cur_byte = cfg.tx_options;
            aftf_pkg::STEP_PAYLOAD: cur_byte = in_byte_reg;
            aftf_pkg::STEP_CSUM:
            begin
                cur_byte = ~sum_reg;
                cur_end = 1'b1;
            end
            default: cur_byte = '0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        in_valid_next = in_valid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (step_reg == aftf_pkg::STEP_SOF)
            begin
                sum_next = '0;
            end
            else if (step_reg >= aftf_pkg::STEP_TYPE && step_reg <= aftf_pkg::STEP_PAYLOAD)
            begin
                sum_next = sum_reg + cur_byte;
            end
            if (step_reg == aftf_pkg::STEP_PAYLOAD)
            begin
                pos_next = pos_inc[aftf_pkg::BYTE_W-1:0];
            end
            if (step_reg == aftf_pkg::STEP_CSUM)
            begin
                pos_next = '0;
                sum_next = '0;
            end
            if (item_done)
            begin
                in_valid_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + aftf_pkg::step_t'(1);
            end
        end
        if (load)
        begin
            in_valid_next = 1'b1;
            step_next = (pos_next == '0) ? aftf_pkg::STEP_SOF : aftf_pkg::STEP_PAYLOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            step_reg <= aftf_pkg::STEP_SOF;
            pos_reg <= '0;
            sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            step_reg <= step_next;
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= s_tdata;
        end
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= item_done;
            out_end_reg <= cur_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_byte_reg;
    assign m_tlast = out_last_reg;
    assign m_tuser = out_end_reg;

    a_csum_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("checksum word without tlast");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= aftf_pkg::STEP_CSUM)
        else $error("sequencer step out of range");

    a_header_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && step_reg == aftf_pkg::STEP_SOF |-> pos_reg == '0)
        else $error("header started inside a frame");

    a_mid_payload_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit && step_reg == aftf_pkg::STEP_PAYLOAD && !frame_done
        |=> m_tvalid && m_tlast && !m_tuser)
        else $error("middle payload word not marked last");

endmodule
